@@ hw/rtl/rgbgwp_pkg.sv @@
package rgbgwp_pkg;

	// frame geometry defaults
	localparam int unsigned LINE_PIXELS_DEF = 320;
	localparam int unsigned FRAME_LINES_DEF = 240;

	// byte buffer between packer and output
	localparam int unsigned OUT_DEPTH = 8;
	localparam int unsigned MAX_BURST = 4;

	// configuration register indexes
	localparam logic [2:0] REG_WINDOW_LEFT    = 3'd0;
	localparam logic [2:0] REG_WINDOW_TOP     = 3'd1;
	localparam logic [2:0] REG_WINDOW_WIDTH   = 3'd2;
	localparam logic [2:0] REG_WINDOW_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd4;

	// gray widths that pack; anything else is a plain byte
	localparam logic [3:0] BPP_1 = 4'd1;
	localparam logic [3:0] BPP_2 = 4'd2;
	localparam logic [3:0] BPP_4 = 4'd4;
	localparam logic [3:0] BPP_6 = 4'd6;

	// luma weights
	localparam logic [7:0] WEIGHT_R = 8'd77;
	localparam logic [7:0] WEIGHT_G = 8'd150;
	localparam logic [7:0] WEIGHT_B = 8'd29;

	typedef struct packed {
		logic [15:0] pixel_word;
		logic [8:0]  column;
		logic [7:0]  row;
		logic        frame_start;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} gray_out_t;

endpackage

@@ hw/rtl/rgb565_gray_window_packer_top.sv @@
// RGB565 to gray window packer. Each request carries one RGB565 pixel with its
// column and row; pixels inside the configured window become 8-bit luma
// (77r + 150g + 29b) >> 8, which is either sent as one byte (width 8 or any
// other value) or cut to its top 1, 2, 4 or 6 bits and packed into a 32-bit
// word sent as 4 bytes (3 for width 6), least significant first. One pixel is
// accepted every cycle unless stalled; it waits in the input register, and its
// bytes go into an 8-entry byte buffer as it leaves. Gray bytes leave one per
// cycle while gray_stall is low. The pixel side stalls only while the byte buffer
// has fewer than 4 free entries, so with gray_stall low a sustained rate of one
// pixel per cycle holds for any width. Configuration writes are taken every cycle
// and must be made while no pixel is in flight and the byte buffer is empty.
module rgb565_gray_window_packer_top #(
	parameter int unsigned LINE_PIXELS = rgbgwp_pkg::LINE_PIXELS_DEF,
	parameter int unsigned FRAME_LINES = rgbgwp_pkg::FRAME_LINES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  rgbgwp_pkg::pixel_in_t pixel,
	output logic                  gray_valid,
	input  logic                  gray_stall,
	output rgbgwp_pkg::gray_out_t gray,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [8:0]            cfg_data
);
	import rgbgwp_pkg::*;

	localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	// configuration registers
	logic [8:0] window_left_q;
	logic [7:0] window_top_q;
	logic [8:0] window_width_q;
	logic [7:0] window_height_q;
	logic [3:0] bits_per_pixel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_left_q    <= '0;
			window_top_q     <= '0;
			window_width_q   <= 9'd300;
			window_height_q  <= 8'd52;
			bits_per_pixel_q <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LEFT:    window_left_q    <= cfg_data;
				REG_WINDOW_TOP:     window_top_q     <= cfg_data[7:0];
				REG_WINDOW_WIDTH:   window_width_q   <= cfg_data;
				REG_WINDOW_HEIGHT:  window_height_q  <= cfg_data[7:0];
				REG_BITS_PER_PIXEL: bits_per_pixel_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	logic      valid_s1;
	pixel_in_t pix_s1;
	logic      consume;
	logic      load;

	logic [CNT_W-1:0] fifo_cnt_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;

	assign consume     = valid_s1 && (fifo_cnt_q <= CNT_W'(OUT_DEPTH - MAX_BURST));
	assign pixel_stall = valid_s1 && !consume;
	assign load        = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load || consume) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1 <= pixel;
		end
	end

	// window test
	logic col_in;
	logic row_in;
	logic keep;

	assign col_in = (32'(pix_s1.column) < 32'(LINE_PIXELS))
		&& (pix_s1.column >= window_left_q)
		&& ((pix_s1.column - window_left_q) < window_width_q);
	assign row_in = (32'(pix_s1.row) < 32'(FRAME_LINES))
		&& (pix_s1.row >= window_top_q)
		&& ((pix_s1.row - window_top_q) < window_height_q);
	assign keep = col_in && row_in;

	// rgb565 expansion and luma
	logic [7:0]  chan_r;
	logic [7:0]  chan_g;
	logic [7:0]  chan_b;
	logic [15:0] luma_sum;
	logic [7:0]  luma;

	assign chan_r   = {pix_s1.pixel_word[15:11], 3'b000};
	assign chan_g   = {pix_s1.pixel_word[10:5], 2'b00};
	assign chan_b   = {pix_s1.pixel_word[4:0], 3'b000};
	assign luma_sum = 16'(chan_r) * 16'(WEIGHT_R) + 16'(chan_g) * 16'(WEIGHT_G)
		+ 16'(chan_b) * 16'(WEIGHT_B);
	assign luma     = luma_sum[15:8];

	// packer
	logic [31:0] pack_acc_q;
	logic [5:0]  pack_cnt_q;
	logic [31:0] acc_base;
	logic [5:0]  cnt_base;
	logic [31:0] acc_or;
	logic [5:0]  cnt_inc;
	logic [31:0] acc_nxt;
	logic [5:0]  cnt_nxt;
	logic [7:0]  mask;
	logic [5:0]  target;
	logic [2:0]  shift;
	logic        packed_mode;
	logic        skip_low;
	logic [2:0]  n_push;
	gray_out_t   burst [MAX_BURST];

	always_comb begin
		acc_base = pix_s1.frame_start ? '0 : pack_acc_q;
		cnt_base = pix_s1.frame_start ? '0 : pack_cnt_q;
		packed_mode = 1'b1;
		mask   = 8'hff;
		target = 6'd1;
		shift  = 3'd0;
		unique case (bits_per_pixel_q)
			BPP_1: begin mask = 8'h80; target = 6'd32; shift = 3'd1; end
			BPP_2: begin mask = 8'hc0; target = 6'd16; shift = 3'd2; end
			BPP_4: begin mask = 8'hf0; target = 6'd8;  shift = 3'd4; end
			BPP_6: begin mask = 8'hfc; target = 6'd4;  shift = 3'd6; end
			default: packed_mode = 1'b0;
		endcase
		skip_low = (bits_per_pixel_q == BPP_6);
		acc_or   = acc_base | {luma & mask, 24'h000000};
		cnt_inc  = cnt_base + 6'd1;
		acc_nxt  = acc_base;
		cnt_nxt  = cnt_base;
		n_push   = 3'd0;
		for (int i = 0; i < MAX_BURST; i++) begin
			burst[i] = '0;
		end
		if (keep) begin
			if (!packed_mode) begin
				burst[0] = '{out_byte: luma, last_of_run: 1'b1};
				n_push   = 3'd1;
			end else if (cnt_inc < target) begin
				acc_nxt = acc_or >> shift;
				cnt_nxt = cnt_inc;
			end else begin
				acc_nxt = '0;
				cnt_nxt = '0;
				if (skip_low) begin
					burst[0] = '{out_byte: acc_or[15:8],  last_of_run: 1'b0};
					burst[1] = '{out_byte: acc_or[23:16], last_of_run: 1'b0};
					burst[2] = '{out_byte: acc_or[31:24], last_of_run: 1'b1};
					n_push   = 3'd3;
				end else begin
					burst[0] = '{out_byte: acc_or[7:0],   last_of_run: 1'b0};
					burst[1] = '{out_byte: acc_or[15:8],  last_of_run: 1'b0};
					burst[2] = '{out_byte: acc_or[23:16], last_of_run: 1'b0};
					burst[3] = '{out_byte: acc_or[31:24], last_of_run: 1'b1};
					n_push   = 3'd4;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_acc_q <= '0;
			pack_cnt_q <= '0;
		end else if (consume) begin
			pack_acc_q <= acc_nxt;
			pack_cnt_q <= cnt_nxt;
		end
	end

	// output byte buffer
	gray_out_t        out_mem [OUT_DEPTH];
	logic [2:0]       push_n;
	logic             pop;

	assign push_n     = consume ? n_push : 3'd0;
	assign gray_valid = (fifo_cnt_q != '0);
	assign gray       = out_mem[rd_ptr_q];
	assign pop        = gray_valid && !gray_stall;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_BURST; i++) begin
			if (3'(i) < push_n) begin
				out_mem[PTR_W'(wr_ptr_q + PTR_W'(i))] <= burst[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= PTR_W'(wr_ptr_q + PTR_W'(push_n));
			rd_ptr_q   <= PTR_W'(rd_ptr_q + PTR_W'(pop));
			fifo_cnt_q <= CNT_W'(fifo_cnt_q + CNT_W'(push_n) - CNT_W'(pop));
		end
	end

	// checks
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= CNT_W'(OUT_DEPTH))
		else $error("byte buffer overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pack_cnt_q < 6'd32)
		else $error("pack count past word size");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		pack_cnt_q == 6'd0 |-> pack_acc_q == 32'd0)
		else $error("stale bits in empty pack word");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(pix_s1))
		else $error("held pixel lost");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> fifo_cnt_q + CNT_W'(MAX_BURST) <= CNT_W'(OUT_DEPTH))
		else $error("pixel taken without buffer room");

endmodule
